// ----- rtl/mqll_pkg.sv -----
// Shared types and constants for the multi-queue linked list manager.
package mqll_pkg;

    localparam int DEF_THREADS = 64;

    typedef enum logic [1:0] {
        MODE_ENQ  = 2'd0,
        MODE_DEQ  = 2'd1,
        MODE_REM  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC1,
        ST_EXEC2,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic enq_wr;
        logic rem_wr1;
        logic rem_wr2;
        logic deq_rd;
        logic deq_wr;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        mode_t op;
        logic  clr_last;
        logic  out_free;
    } ctl_stat_t;

endpackage

// ----- rtl/multi_queue_linked_list_manager_top.sv -----
// Top level of the multi-queue linked list manager: controller plus table datapath.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------
//   in      | input     | in_valid / in_stall | mode, queue_id, thread_id
//   out     | output    | out_valid/out_stall | popped_thread, queue_was_empty
//
// After reset a clearing pass writes the sentinel through all tables, with
// in_stall high.
// An enqueue or an unknown mode finishes in the state after acceptance; a
// dequeue or remove needs a second execute state, set by the registered table
// reads and the dependent second read or write.
// One item is worked at a time; a result held by out_stall keeps the block in
// its wait state, and in_stall stays high until the result register frees.
module multi_queue_linked_list_manager_top #(
    parameter int THREADS = mqll_pkg::DEF_THREADS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          mode,
    input  logic [$clog2(THREADS + 1) - 1:0]    queue_id,
    input  logic [$clog2(THREADS) - 1:0]        thread_id,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [$clog2(THREADS + 1) - 1:0]    popped_thread,
    output logic                                queue_was_empty
);
    import mqll_pkg::*;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    mqll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    mqll_datapath #(
        .THREADS (THREADS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .mode            (mode),
        .queue_id        (queue_id),
        .thread_id       (thread_id),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .popped_thread   (popped_thread),
        .queue_was_empty (queue_was_empty)
    );

endmodule

// ----- rtl/mqll_ctrl.sv -----
// Controller state machine: sequences clearing, table reads, writes and result load.
module mqll_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mqll_pkg::ctl_stat_t  stat,
    output mqll_pkg::ctl_cmd_t   cmd
);
    import mqll_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC1;
                end
            end
            ST_EXEC1:
            begin
                unique case (stat.op)
                    MODE_ENQ:
                    begin
                        cmd.enq_wr = 1'b1;
                        // finish here: load result if the output slot frees
                        cmd.load_out = stat.out_free;
                        state_next   = stat.out_free ? ST_IDLE : ST_WAIT;
                    end
                    MODE_DEQ:
                    begin
                        cmd.deq_rd = 1'b1;
                        state_next = ST_EXEC2;
                    end
                    MODE_REM:
                    begin
                        cmd.rem_wr1 = 1'b1;
                        state_next  = ST_EXEC2;
                    end
                    MODE_NONE:
                    begin
                        cmd.load_out = stat.out_free;
                        state_next   = stat.out_free ? ST_IDLE : ST_WAIT;
                    end
                endcase
            end
            ST_EXEC2:
            begin
                cmd.deq_wr   = (stat.op == MODE_DEQ);
                cmd.rem_wr2  = (stat.op == MODE_REM);
                cmd.load_out = stat.out_free;
                state_next   = stat.out_free ? ST_IDLE : ST_WAIT;
            end
            ST_WAIT:
            begin
                // hold the result until the output slot frees
                cmd.load_out = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/mqll_datapath.sv -----
// Datapath: head, tail, prev and next tables, item registers and result register.
module mqll_datapath #(
    parameter int THREADS = mqll_pkg::DEF_THREADS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mqll_pkg::ctl_cmd_t                  cmd,
    output mqll_pkg::ctl_stat_t                 stat,
    input  logic [1:0]                          mode,
    input  logic [$clog2(THREADS + 1) - 1:0]    queue_id,
    input  logic [$clog2(THREADS) - 1:0]        thread_id,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [$clog2(THREADS + 1) - 1:0]    popped_thread,
    output logic                                queue_was_empty
);
    import mqll_pkg::*;

    localparam int NUM_QUEUES = THREADS + 1;
    localparam int QW         = $clog2(THREADS + 1);
    localparam int TW         = $clog2(THREADS);
    localparam logic [QW-1:0] NIL = QW'(THREADS);

    function automatic logic is_thread(input logic [QW-1:0] v);
        return (v < NIL);
    endfunction

    // tables
    logic [QW-1:0] head_mem [NUM_QUEUES];
    logic [QW-1:0] tail_mem [NUM_QUEUES];
    logic [QW-1:0] prev_mem [THREADS];
    logic [QW-1:0] next_mem [THREADS];

    logic [QW-1:0] head_rd;
    logic [QW-1:0] tail_rd;
    logic [QW-1:0] prev_rd;
    logic [QW-1:0] next_rd;

    // item registers
    mode_t         mode_reg;
    logic [QW-1:0] q_reg;
    logic [TW-1:0] t_reg;
    logic [QW-1:0] first_reg;

    logic [QW-1:0] clr_cnt_reg;
    logic [QW-1:0] clr_cnt_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [QW-1:0] popped_reg;
    logic          empty_reg;

    logic          q_ok;
    logic          item_ok;
    logic [QW-1:0] t_val;
    logic [QW-1:0] p_norm;
    logic [QW-1:0] n_norm;
    logic [QW-1:0] after_norm;
    logic          first_ok;

    logic          head_we;
    logic [QW-1:0] head_waddr;
    logic [QW-1:0] head_wdata;
    logic          tail_we;
    logic [QW-1:0] tail_waddr;
    logic [QW-1:0] tail_wdata;
    logic          prev_we;
    logic [TW-1:0] prev_waddr;
    logic [QW-1:0] prev_wdata;
    logic          next_we;
    logic [TW-1:0] next_waddr;
    logic [QW-1:0] next_wdata;

    assign q_ok       = (q_reg <= NIL);
    assign item_ok    = q_ok && ({1'b0, t_reg} < (TW + 1)'(THREADS));
    assign t_val      = QW'(t_reg);
    assign p_norm     = is_thread(prev_rd) ? prev_rd : NIL;
    assign n_norm     = is_thread(next_rd) ? next_rd : NIL;
    assign after_norm = n_norm;
    assign first_ok   = q_ok && is_thread(first_reg);

    // head table writes
    always_comb
    begin
        head_we    = 1'b0;
        head_waddr = q_reg;
        head_wdata = NIL;
        if (cmd.clr_step)
        begin
            head_we    = 1'b1;
            head_waddr = clr_cnt_reg;
        end
        else if (cmd.enq_wr && item_ok && !is_thread(tail_rd))
        begin
            head_we    = 1'b1;
            head_wdata = t_val;
        end
        else if (cmd.rem_wr1 && item_ok && (head_rd == t_val))
        begin
            head_we    = 1'b1;
            head_wdata = n_norm;
        end
        else if (cmd.deq_wr && first_ok)
        begin
            head_we    = 1'b1;
            head_wdata = after_norm;
        end
    end

    // tail table writes
    always_comb
    begin
        tail_we    = 1'b0;
        tail_waddr = q_reg;
        tail_wdata = NIL;
        if (cmd.clr_step)
        begin
            tail_we    = 1'b1;
            tail_waddr = clr_cnt_reg;
        end
        else if (cmd.enq_wr && item_ok)
        begin
            tail_we    = 1'b1;
            tail_wdata = t_val;
        end
        else if (cmd.rem_wr1 && item_ok && (tail_rd == t_val))
        begin
            tail_we    = 1'b1;
            tail_wdata = p_norm;
        end
        else if (cmd.deq_wr && first_ok && !is_thread(after_norm))
        begin
            tail_we = 1'b1;
        end
    end

    // prev link writes; the thread's own links are cleared in the cycle after
    // its neighbors are patched so that the own-link write wins
    always_comb
    begin
        prev_we    = 1'b0;
        prev_waddr = t_reg;
        prev_wdata = NIL;
        if (cmd.clr_step)
        begin
            prev_we    = (clr_cnt_reg < NIL);
            prev_waddr = clr_cnt_reg[TW-1:0];
        end
        else if (cmd.enq_wr && item_ok && is_thread(tail_rd))
        begin
            prev_we    = 1'b1;
            prev_wdata = tail_rd;
        end
        else if (cmd.rem_wr1 && item_ok && is_thread(n_norm))
        begin
            prev_we    = 1'b1;
            prev_waddr = n_norm[TW-1:0];
            prev_wdata = p_norm;
        end
        else if (cmd.rem_wr2 && item_ok)
        begin
            prev_we = 1'b1;
        end
        else if (cmd.deq_wr && first_ok && is_thread(after_norm))
        begin
            prev_we    = 1'b1;
            prev_waddr = after_norm[TW-1:0];
        end
    end

    // next link writes
    always_comb
    begin
        next_we    = 1'b0;
        next_waddr = t_reg;
        next_wdata = NIL;
        if (cmd.clr_step)
        begin
            next_we    = (clr_cnt_reg < NIL);
            next_waddr = clr_cnt_reg[TW-1:0];
        end
        else if (cmd.enq_wr && item_ok && is_thread(tail_rd))
        begin
            next_we    = 1'b1;
            next_waddr = tail_rd[TW-1:0];
            next_wdata = t_val;
        end
        else if (cmd.rem_wr1 && item_ok && is_thread(p_norm))
        begin
            next_we    = 1'b1;
            next_waddr = p_norm[TW-1:0];
            next_wdata = n_norm;
        end
        else if (cmd.rem_wr2 && item_ok)
        begin
            next_we = 1'b1;
        end
        else if (cmd.deq_wr && first_ok)
        begin
            next_we    = 1'b1;
            next_waddr = first_reg[TW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (cmd.accept)
        begin
            head_rd <= head_mem[queue_id];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_we)
        begin
            tail_mem[tail_waddr] <= tail_wdata;
        end
        if (cmd.accept)
        begin
            tail_rd <= tail_mem[queue_id];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (cmd.accept)
        begin
            prev_rd <= prev_mem[thread_id];
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (cmd.accept)
        begin
            next_rd <= next_mem[thread_id];
        end
        else if (cmd.deq_rd)
        begin
            // follow the popped head to its successor
            next_rd <= next_mem[head_rd[TW-1:0]];
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= mode_t'(mode);
            q_reg    <= queue_id;
            t_reg    <= thread_id;
        end
        if (cmd.deq_rd)
        begin
            first_reg <= head_rd;
        end
        if (cmd.load_out)
        begin
            popped_reg <= ((mode_reg == MODE_DEQ) && first_ok) ? first_reg : NIL;
            empty_reg  <= (mode_reg == MODE_DEQ) && !first_ok;
        end
    end

    assign clr_cnt_next   = cmd.clr_step ? (clr_cnt_reg + QW'(1)) : clr_cnt_reg;
    assign out_valid_next = cmd.load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.op       = mode_reg;
    assign stat.clr_last = (clr_cnt_reg == NIL);
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid       = out_valid_reg;
    assign popped_thread   = popped_reg;
    assign queue_was_empty = empty_reg;

endmodule

// ----- rtl/mqll_checker.sv -----
// Port-level assertions for the multi-queue linked list manager, bound to the top level.
module mqll_checker #(
    parameter int THREADS = mqll_pkg::DEF_THREADS
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [$clog2(THREADS + 1) - 1:0]    popped_thread,
    input logic                                queue_was_empty
);
    localparam int QW = $clog2(THREADS + 1);

    // an empty dequeue reports the sentinel
    a_empty_nil: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && queue_was_empty |-> popped_thread == QW'(THREADS))
        else $error("empty result without sentinel thread");

    // one item at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an item was accepted");

    // a new result appears only while an item is in work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no item in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(popped_thread)
            && $stable(queue_was_empty))
        else $error("stalled result changed");

endmodule

bind multi_queue_linked_list_manager_top mqll_checker #(.THREADS(THREADS)) u_mqll_checker (.*);

// ----- tb/sv/tb_top.sv -----
// Testbench for the multi-queue linked list manager: random queue traffic checked against a linked-list predictor.
`timescale 1ns / 1ps

module tb_top;
    import mqll_pkg::*;

    localparam int THREADS = DEF_THREADS;
    localparam int QW = $clog2(THREADS + 1);
    localparam int TW = $clog2(THREADS);
    localparam logic [QW-1:0] NIL = QW'(THREADS);
    localparam int RANDOM_OPS = 1650;

    typedef struct packed {
        mode_t         op;
        logic [QW-1:0] q;
        logic [TW-1:0] t;
    } queue_op_t;

    typedef struct packed {
        logic [QW-1:0] popped;
        logic          empty;
    } pop_result_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_style_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] mode = '0;
    logic [QW-1:0] queue_id = '0;
    logic [TW-1:0] thread_id = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [QW-1:0] popped_thread;
    logic queue_was_empty;

    // Predicted list state
    logic [QW-1:0] head_of [0:THREADS];
    logic [QW-1:0] tail_of [0:THREADS];
    logic [QW-1:0] prev_of [0:THREADS-1];
    logic [QW-1:0] next_of [0:THREADS-1];

    queue_op_t   ops_to_send[$];
    pop_result_t expected_pops[$];
    int          total_ops = 0;
    int          accepted_ops = 0;
    int          fail_cnt = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          rx_cycles = 0;
    rx_style_t   rx_style = RX_FREE;

    // Shadow of well-formed queue contents, used only to shape the stimulus
    logic [TW-1:0] members [0:THREADS][$];
    int            owner [0:THREADS-1];

    multi_queue_linked_list_manager_top #(
        .THREADS(THREADS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .queue_id(queue_id),
        .thread_id(thread_id),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .popped_thread(popped_thread),
        .queue_was_empty(queue_was_empty)
    );

    always #5 clk = ~clk;

    function automatic bit is_thread(input logic [QW-1:0] v);
        return v < QW'(THREADS);
    endfunction

    function automatic pop_result_t apply_queue_op(input mode_t op, input logic [QW-1:0] q,
                                                   input logic [TW-1:0] t);
        pop_result_t   res;
        logic [QW-1:0] tt;
        logic [QW-1:0] first;
        logic [QW-1:0] after;
        logic [QW-1:0] last;
        logic [QW-1:0] h;
        logic [QW-1:0] tl;
        logic [QW-1:0] p;
        logic [QW-1:0] n;
        res.popped = NIL;
        res.empty = 1'b0;
        tt = QW'(t);
        if (q > QW'(THREADS))
        begin
            if (op == MODE_DEQ)
                res.empty = 1'b1;
        end
        else
        begin
            case (op)
                MODE_ENQ:
                begin
                    last = tail_of[q];
                    if (!is_thread(last))
                        head_of[q] = tt;
                    else
                    begin
                        prev_of[t] = last;
                        next_of[last[TW-1:0]] = tt;
                    end
                    tail_of[q] = tt;
                end
                MODE_DEQ:
                begin
                    first = head_of[q];
                    if (!is_thread(first))
                        res.empty = 1'b1;
                    else
                    begin
                        after = next_of[first[TW-1:0]];
                        if (!is_thread(after))
                            tail_of[q] = NIL;
                        else
                            prev_of[after[TW-1:0]] = NIL;
                        next_of[first[TW-1:0]] = NIL;
                        head_of[q] = is_thread(after) ? after : NIL;
                        res.popped = first;
                    end
                end
                MODE_REM:
                begin
                    h = head_of[q];
                    tl = tail_of[q];
                    p = is_thread(prev_of[t]) ? prev_of[t] : NIL;
                    n = is_thread(next_of[t]) ? next_of[t] : NIL;
                    // Order of writes matters when a thread links to itself
                    if (h == tt)
                        head_of[q] = n;
                    if (tl == tt)
                        tail_of[q] = p;
                    if (p != NIL)
                        next_of[p[TW-1:0]] = n;
                    if (n != NIL)
                        prev_of[n[TW-1:0]] = p;
                    prev_of[t] = NIL;
                    next_of[t] = NIL;
                end
                default:
                begin
                end
            endcase
        end
        return res;
    endfunction

    task automatic add_op(input mode_t op, input int q, input int t);
        queue_op_t item;
        item.op = op;
        item.q = QW'(q);
        item.t = TW'(t);
        ops_to_send.push_back(item);
    endtask

    task automatic report_fail(input string what, input pop_result_t want);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t: %s: got popped=%0d empty=%0d, expected popped=%0d empty=%0d",
                     $realtime, what, popped_thread, queue_was_empty, want.popped, want.empty);
    endtask

    // Driver: bursts of items with random gaps; hold the item while stalled
    always @(posedge clk or negedge rst_n)
    begin : driver
        queue_op_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= '0;
            queue_id <= '0;
            thread_id <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_pops.push_back(apply_queue_op(mode_t'(mode), queue_id, thread_id));
                accepted_ops++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0 || ops_to_send.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    nxt = ops_to_send.pop_front();
                    in_valid <= 1'b1;
                    mode <= nxt.op;
                    queue_id <= nxt.q;
                    thread_id <= nxt.t;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
            end
        end
    end

    // Monitor: check each result, and stall on a changing pattern
    always @(posedge clk or negedge rst_n)
    begin : monitor
        pop_result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pops.size() == 0)
                begin
                    want.popped = NIL;
                    want.empty = 1'b0;
                    report_fail("unexpected result", want);
                end
                else
                begin
                    want = expected_pops.pop_front();
                    if (popped_thread !== want.popped || queue_was_empty !== want.empty)
                        report_fail("result mismatch", want);
                end
            end
            rx_cycles++;
            if (rx_cycles % 128 == 0)
                rx_style = rx_style_t'($urandom_range(0, 3));
            case (rx_style)
                RX_FREE:     out_stall <= 1'b0;
                RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= ((rx_cycles % 8) >= 5);
            endcase
        end
    end

    initial
    begin
        int i;
        int r;
        int c;
        int q;
        int t;
        int sz;
        int idx;
        int tries;
        int qid;
        for (i = 0; i <= THREADS; i++)
        begin
            head_of[i] = NIL;
            tail_of[i] = NIL;
        end
        for (i = 0; i < THREADS; i++)
        begin
            prev_of[i] = NIL;
            next_of[i] = NIL;
            owner[i] = -1;
        end

        // Empty and out-of-range queues, unknown mode
        add_op(MODE_DEQ, 0, 63);
        add_op(MODE_DEQ, THREADS, 0);
        add_op(MODE_DEQ, 127, 21);
        add_op(MODE_NONE, 42, 42);
        add_op(MODE_ENQ, 100, 5);
        add_op(MODE_REM, 127, 5);
        // Remove from the middle and from the tail
        add_op(MODE_ENQ, 0, 0);
        add_op(MODE_ENQ, 0, 63);
        add_op(MODE_ENQ, 0, 31);
        add_op(MODE_REM, 0, 63);
        add_op(MODE_REM, 0, 31);
        // Last queue: dequeue, then remove the sole member
        add_op(MODE_ENQ, THREADS, 63);
        add_op(MODE_ENQ, THREADS, 1);
        add_op(MODE_DEQ, THREADS, 0);
        add_op(MODE_REM, THREADS, 1);
        add_op(MODE_DEQ, THREADS, 0);
        add_op(MODE_DEQ, 0, 0);
        add_op(MODE_DEQ, 0, 0);
        // Remove through the wrong queue id
        add_op(MODE_ENQ, 5, 7);
        add_op(MODE_ENQ, 5, 8);
        add_op(MODE_REM, 6, 8);
        add_op(MODE_DEQ, 5, 0);
        // Same thread enqueued twice links to itself
        add_op(MODE_ENQ, 9, 9);
        add_op(MODE_ENQ, 9, 9);
        add_op(MODE_DEQ, 9, 0);
        add_op(MODE_REM, 9, 9);

        for (i = 0; i < RANDOM_OPS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                add_op(mode_t'($urandom_range(0, 3)), $urandom_range(THREADS + 1, 127),
                       $urandom_range(0, THREADS - 1));
            else if (r < 7)
                add_op(MODE_NONE, $urandom_range(0, 127), $urandom_range(0, THREADS - 1));
            else if (r < 10)
            begin
                q = $urandom_range(0, THREADS);
                if (members[q].size() == 0)
                    add_op(MODE_DEQ, q, $urandom_range(0, THREADS - 1));
                else
                    add_op(MODE_NONE, q, $urandom_range(0, THREADS - 1));
            end
            else if (r < 12)
            begin
                // Unlinked thread: remove should leave everything alone
                t = $urandom_range(0, THREADS - 1);
                if (owner[t] < 0)
                    add_op(MODE_REM, $urandom_range(0, THREADS), t);
                else
                    add_op(MODE_NONE, $urandom_range(0, 127), t);
            end
            else if (r < 13)
                // Broken sequence: enqueue with no regard to current membership
                add_op(MODE_ENQ, $urandom_range(0, THREADS), $urandom_range(0, THREADS - 1));
            else
            begin
                c = $urandom_range(0, 4);
                q = ($urandom_range(0, 4) == 0) ? $urandom_range(0, THREADS)
                                                 : ((c < 3) ? c : c + THREADS - 4);
                sz = members[q].size();
                c = $urandom_range(0, 99);
                if (sz == 0 || c < 45)
                begin
                    tries = 0;
                    t = $urandom_range(0, THREADS - 1);
                    while (owner[t] >= 0 && tries < 8)
                    begin
                        t = $urandom_range(0, THREADS - 1);
                        tries++;
                    end
                    if (owner[t] < 0)
                    begin
                        add_op(MODE_ENQ, q, t);
                        members[q].push_back(TW'(t));
                        owner[t] = q;
                    end
                    else
                    begin
                        add_op(MODE_DEQ, q, $urandom_range(0, THREADS - 1));
                        if (sz > 0)
                        begin
                            owner[members[q][0]] = -1;
                            void'(members[q].pop_front());
                        end
                    end
                end
                else if (c < 75)
                begin
                    add_op(MODE_DEQ, q, $urandom_range(0, THREADS - 1));
                    owner[members[q][0]] = -1;
                    void'(members[q].pop_front());
                end
                else
                begin
                    idx = $urandom_range(0, sz - 1);
                    t = members[q][idx];
                    qid = q;
                    // A middle thread can be unlinked through any queue id
                    if (idx != 0 && idx != sz - 1 && $urandom_range(0, 2) == 0)
                        qid = $urandom_range(0, THREADS);
                    add_op(MODE_REM, qid, t);
                    members[q].delete(idx);
                    owner[t] = -1;
                end
            end
        end
        total_ops = ops_to_send.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_ops < total_ops || expected_pops.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
